@@ sv/ycbcr_to_rgba_block_stats_assert.svh @@
// ----------------------------------------------------------------------------
// ycbcr_to_rgba_block_stats_assert.svh
// assertion macros used by the checker file ycrs_checker.sv
// ----------------------------------------------------------------------------
`ifndef YCBCR_TO_RGBA_BLOCK_STATS_ASSERT_SVH
`define YCBCR_TO_RGBA_BLOCK_STATS_ASSERT_SVH

// checked only outside reset
`define YRS_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define YRS_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/ycrs_pkg.sv @@
// ----------------------------------------------------------------------------
// ycrs_pkg
// types, constants and helper functions of the ycbcr to rgba converter
// ----------------------------------------------------------------------------
package ycrs_pkg;

  localparam int PIX_W     = 8;
  localparam int SUM_W     = 18;
  localparam int FRAC_BITS = 10;
  localparam int COEF_W    = 12;
  localparam int OPD_W     = 9;
  localparam int PROD_W    = COEF_W + OPD_W;
  localparam int ACC_W     = 22;
  localparam int WORD_W    = 32;

  localparam int DEF_MAX_GROUP_PIXELS = 256;

  localparam logic [1:0] CHAN_R = 2'd0;
  localparam logic [1:0] CHAN_G = 2'd1;
  localparam logic [1:0] CHAN_B = 2'd2;
  localparam logic [1:0] CHAN_A = 2'd3;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_STATS = 1'b1;

  localparam logic signed [COEF_W-1:0] COEF_CR_R = 12'sd1436;
  localparam logic signed [COEF_W-1:0] COEF_CB_G = -12'sd352;
  localparam logic signed [COEF_W-1:0] COEF_CR_G = -12'sd732;
  localparam logic signed [COEF_W-1:0] COEF_CB_B = 12'sd1815;

  localparam logic [PIX_W-1:0] CHROMA_BIAS = 8'd128;
  localparam logic [PIX_W-1:0] PIX_MAX     = 8'd255;

  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] chroma_blue;
    logic [PIX_W-1:0] chroma_red;
    logic             group_end;
  } in_beat_t;

  typedef struct packed {
    logic              result_kind;
    logic [WORD_W-1:0] pixel_word;
    logic [WORD_W-1:0] min_word;
    logic [WORD_W-1:0] avg_word;
    logic [WORD_W-1:0] max_word;
    logic              last_of_run;
  } out_beat_t;

  // coefficient of each multiply step: R, G (two steps), B
  function automatic logic signed [COEF_W-1:0] coef_for_step(input logic [1:0] step);
    logic signed [COEF_W-1:0] c;
    case (step)
      2'd0:    c = COEF_CR_R;
      2'd1:    c = COEF_CB_G;
      2'd2:    c = COEF_CR_G;
      default: c = COEF_CB_B;
    endcase
    return c;
  endfunction

  // floor shift out the fraction, then clamp to 0..255
  function automatic logic [PIX_W-1:0] clamp_q10(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] s;
    logic [PIX_W-1:0]        r;
    s = acc >>> FRAC_BITS;
    if (s[ACC_W-1]) begin
      r = '0;
    end else if (s > $signed({{(ACC_W-PIX_W){1'b0}}, PIX_MAX})) begin
      r = PIX_MAX;
    end else begin
      r = s[PIX_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ sv/ycbcr_to_rgba_block_stats.sv @@
// ----------------------------------------------------------------------------
// ycbcr_to_rgba_block_stats
// ycbcr pixel to rgba conversion with per-group channel statistics
// ----------------------------------------------------------------------------
// Input beats (in_valid/in_stall) carry one pixel: luma, chroma_blue,
// chroma_red and group_end. Output beats (out_valid/out_stall) carry one
// result: a converted pixel, and after the last pixel of a group a
// statistics record with per-channel min, truncated average and max.
// cfg_we/cfg_data write color_mode; write it only while the block is idle.
// A color pixel runs four steps through one shared multiply-accumulate unit,
// then the clamp, statistics and output-load states (S_LASTB, S_ALPHA,
// S_PIX) before its result is offered. A gray pixel goes straight to S_PIX.
// The input stalls until the result is loaded, so the block takes no new
// pixel while the last one is still in flight.
// At a group end the averages come from one restoring divider run once per
// channel, R, G, B and then A, so the statistics record follows the pixel
// result and the next pixel is taken only once the record is loaded.
// The output register lets the next pixel be accepted while a result waits;
// a stalled receiver holds the result and the block waits to write the next.
// Synchronous reset sets color mode, empties the statistics and the output.
// ----------------------------------------------------------------------------
module ycbcr_to_rgba_block_stats
  import ycrs_pkg::*;
#(
  parameter int MAX_GROUP_PIXELS = DEF_MAX_GROUP_PIXELS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_data
);

  localparam int CNT_W = $clog2(MAX_GROUP_PIXELS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_LASTB = 3'd2;
  localparam logic [2:0] S_ALPHA = 3'd3;
  localparam logic [2:0] S_PIX   = 3'd4;
  localparam logic [2:0] S_DIVS  = 3'd5;
  localparam logic [2:0] S_DIVW  = 3'd6;
  localparam logic [2:0] S_STAT  = 3'd7;

  logic [2:0]       state;
  logic [1:0]       step;
  logic [1:0]       chan;
  logic             color_mode;
  logic [PIX_W-1:0] luma_q;
  logic [PIX_W-1:0] cb_q;
  logic [PIX_W-1:0] cr_q;
  logic             group_end_q;
  logic             upd;
  logic             pend_valid;
  logic [1:0]       pend_chan;
  logic [PIX_W-1:0] pix_ch [3];
  logic [PIX_W-1:0] ch_min [4];
  logic [PIX_W-1:0] ch_max [4];
  logic [SUM_W-1:0] ch_sum [4];
  logic [PIX_W-1:0] avg_ch [4];
  logic [CNT_W-1:0] pixel_count;

  logic                     accept;
  logic                     out_free;
  logic                     mac_en;
  logic                     mac_load;
  logic signed [ACC_W-1:0]  mac_base;
  logic signed [COEF_W-1:0] mac_coef;
  logic signed [OPD_W-1:0]  mac_op;
  logic signed [ACC_W-1:0]  acc;
  logic [PIX_W-1:0]         cval;
  logic [1:0]               stat_idx;
  logic [PIX_W-1:0]         stat_val;
  logic                     stat_we;
  logic [SUM_W-1:0]         sum_rd;
  logic                     div_start;
  logic                     div_done;
  logic [SUM_W-1:0]         div_q;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // multiply steps: 0 R, 1 and 2 G, 3 B
  assign mac_en   = (state == S_MUL);
  assign mac_load = (step != 2'd2);
  assign mac_base = $signed({{(ACC_W-PIX_W-FRAC_BITS){1'b0}}, luma_q, {FRAC_BITS{1'b0}}});
  assign mac_coef = coef_for_step(step);
  assign mac_op   = (step == 2'd0 || step == 2'd2)
                  ? $signed({1'b0, cr_q}) - $signed({1'b0, CHROMA_BIAS})
                  : $signed({1'b0, cb_q}) - $signed({1'b0, CHROMA_BIAS});

  ycrs_mac u_mac (
    .clk  (clk),
    .en   (mac_en),
    .load (mac_load),
    .base (mac_base),
    .coef (mac_coef),
    .op   (mac_op),
    .acc  (acc)
  );

  assign cval = clamp_q10(acc);

  // one statistics port: channel update, alpha update or divider feed
  always_comb begin
    if (state == S_ALPHA) begin
      stat_idx = CHAN_A;
      stat_val = PIX_MAX;
    end else if (state == S_DIVS) begin
      stat_idx = chan;
      stat_val = cval;
    end else begin
      stat_idx = pend_chan;
      stat_val = cval;
    end
  end

  assign stat_we   = upd && (pend_valid || state == S_ALPHA);
  assign sum_rd    = ch_sum[stat_idx];
  assign div_start = (state == S_DIVS);

  ycrs_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_rd),
    .divisor  (pixel_count),
    .done     (div_done),
    .quotient (div_q)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step       <= '0;
      chan       <= '0;
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= (state == S_MUL) && (step != 2'd1);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            step  <= '0;
            state <= color_mode ? S_MUL : S_PIX;
          end
        end
        S_MUL: begin
          step <= step + 2'd1;
          if (step == 2'd3) begin
            state <= S_LASTB;
          end
        end
        S_LASTB: state <= S_ALPHA;
        S_ALPHA: state <= S_PIX;
        S_PIX: begin
          if (out_free) begin
            chan  <= CHAN_R;
            state <= group_end_q ? S_DIVS : S_IDLE;
          end
        end
        S_DIVS: state <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            if (chan == CHAN_A) begin
              state <= S_STAT;
            end else begin
              chan  <= chan + 2'd1;
              state <= S_DIVS;
            end
          end
        end
        S_STAT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    pend_chan <= (step == 2'd0) ? CHAN_R : (step == 2'd2) ? CHAN_G : CHAN_B;
  end

  // captured beat and clamped channels
  always_ff @(posedge clk) begin
    if (accept) begin
      luma_q      <= in_data.luma;
      cb_q        <= in_data.chroma_blue;
      cr_q        <= in_data.chroma_red;
      group_end_q <= in_data.group_end;
      if (!color_mode) begin
        pix_ch[0] <= in_data.luma;
        pix_ch[1] <= in_data.luma;
        pix_ch[2] <= in_data.luma;
      end
    end
    if (pend_valid) begin
      pix_ch[pend_chan] <= cval;
    end
    if (state == S_DIVW && div_done) begin
      avg_ch[chan] <= (pixel_count == '0) ? '0 : div_q[PIX_W-1:0];
    end
  end

  // mode and statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode  <= 1'b1;
      upd         <= 1'b0;
      pixel_count <= '0;
      for (int i = 0; i < 4; i++) begin
        ch_min[i] <= PIX_MAX;
        ch_max[i] <= '0;
        ch_sum[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        color_mode <= cfg_data;
      end
      if (accept) begin
        upd <= color_mode && (pixel_count < CNT_W'(MAX_GROUP_PIXELS));
      end
      if (stat_we) begin
        ch_sum[stat_idx] <= sum_rd + SUM_W'(stat_val);
        if (stat_val < ch_min[stat_idx]) begin
          ch_min[stat_idx] <= stat_val;
        end
        if (stat_val > ch_max[stat_idx]) begin
          ch_max[stat_idx] <= stat_val;
        end
      end
      if (state == S_ALPHA && upd) begin
        pixel_count <= pixel_count + CNT_W'(1);
      end
      if (state == S_STAT && out_free) begin
        pixel_count <= '0;
        for (int i = 0; i < 4; i++) begin
          ch_min[i] <= PIX_MAX;
          ch_max[i] <= '0;
          ch_sum[i] <= '0;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_PIX && out_free) begin
      out_valid <= 1'b1;
    end else if (state == S_STAT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PIX && out_free) begin
      out_data.result_kind <= KIND_PIXEL;
      out_data.pixel_word  <= {PIX_MAX, pix_ch[2], pix_ch[1], pix_ch[0]};
      out_data.min_word    <= '0;
      out_data.avg_word    <= '0;
      out_data.max_word    <= '0;
      out_data.last_of_run <= !group_end_q;
    end else if (state == S_STAT && out_free) begin
      out_data.result_kind <= KIND_STATS;
      out_data.pixel_word  <= '0;
      out_data.min_word    <= {ch_min[3], ch_min[2], ch_min[1], ch_min[0]};
      out_data.avg_word    <= {avg_ch[3], avg_ch[2], avg_ch[1], avg_ch[0]};
      out_data.max_word    <= {ch_max[3], ch_max[2], ch_max[1], ch_max[0]};
      out_data.last_of_run <= 1'b1;
    end
  end

endmodule

@@ sv/ycrs_mac.sv @@
// ----------------------------------------------------------------------------
// ycrs_mac
// shared multiply-accumulate unit: acc = (load ? base : acc) + coef * op
// ----------------------------------------------------------------------------
module ycrs_mac
  import ycrs_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic                     load,
  input  logic signed [ACC_W-1:0]  base,
  input  logic signed [COEF_W-1:0] coef,
  input  logic signed [OPD_W-1:0]  op,
  output logic signed [ACC_W-1:0]  acc
);

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  addend;

  assign prod     = coef * op;
  assign prod_ext = $signed({{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod});
  assign addend   = load ? base : acc;

  always_ff @(posedge clk) begin
    if (en) begin
      acc <= addend + prod_ext;
    end
  end

endmodule

@@ sv/ycrs_div.sv @@
// ----------------------------------------------------------------------------
// ycrs_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ycrs_div
  import ycrs_pkg::*;
#(
  parameter int DVD_W = SUM_W,
  parameter int DVS_W = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] rem;
  logic [DVD_W-1:0] dq;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  assign trial    = {rem, dq[DVD_W-1]};
  assign diff     = trial - {1'b0, dvs};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(DVD_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // datapath, quotient bits shift in as dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dq  <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      dq  <= {dq[DVD_W-2:0], fits};
    end
  end

endmodule

@@ sv/ycrs_checker.sv @@
// ----------------------------------------------------------------------------
// ycrs_checker
// port-level checks of the ycbcr to rgba converter, bound to the top level
// ----------------------------------------------------------------------------
`include "ycbcr_to_rgba_block_stats_assert.svh"

module ycrs_checker
  import ycrs_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_data
);

  // a stalled output beat holds
  `YRS_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled output beat changed")

  // reset empties the output register
  `YRS_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !out_valid, "output valid after reset")

  // an accepted beat keeps the block busy for at least the next cycle
  `YRS_ASSERT(a_busy_after_accept, clk, rst, in_valid && !in_stall |=> in_stall, "input taken twice in a row")

  // pixel beats carry opaque alpha and no statistics
  `YRS_ASSERT(a_pixel_form, clk, rst, out_valid && out_data.result_kind == KIND_PIXEL |-> out_data.pixel_word[31:24] == PIX_MAX && out_data.min_word == '0 && out_data.max_word == '0, "malformed pixel beat")

  // statistics beats close the run and have alpha minimum 255
  `YRS_ASSERT(a_stats_form, clk, rst, out_valid && out_data.result_kind == KIND_STATS |-> out_data.last_of_run && out_data.pixel_word == '0 && out_data.min_word[31:24] == PIX_MAX, "malformed statistics beat")

endmodule

bind ycbcr_to_rgba_block_stats ycrs_checker u_ycrs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
